>>> rtl/core/lobm_pkg.sv
// Shared types and status codes for the limit order book matcher.
`default_nettype none
package lobm_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_FILL      = 3'd0,
    ST_FULL_FILL = 3'd1,
    ST_RESTED    = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_BOOK_FULL = 3'd5
  } status_e;

  // Request kinds.
  typedef enum logic {
    REQ_NEW    = 1'b0,
    REQ_CANCEL = 1'b1
  } req_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_EMIT,
    S_FINAL
  } state_e;

  // Search command broadcast to the cells.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_MATCH,
    CMD_CANCEL
  } cmd_e;

endpackage : lobm_pkg
`default_nettype wire

>>> rtl/core/limit_order_book_matcher.sv
// Top level: controller plus a chain of book cells.
// Each search sweeps the chain of cells; once the output register is free the
// winner is applied and its result item is offered in the next cycle.
// A new order sweeps once per fill, and once more unless it is fully filled;
// a cancel sweeps once. One item is handled at a time.
// Reset clears all slot valid bits and the arrival counter at once.
`default_nettype none
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = 32,
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 24,
  parameter int ID_BITS    = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid,
  output logic        s_tready,
  // tdata: req_type, order_id, side, limit_price, quantity (from bit 0 up)
  input  wire [((2+ID_BITS+PRICE_BITS+QTY_BITS+7)/8)*8-1:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // tdata: status, maker_id, fill_qty, fill_price (from bit 0 up)
  output logic [((3+ID_BITS+QTY_BITS+PRICE_BITS+7)/8)*8-1:0] m_tdata,
  output logic        m_tlast
);

  localparam int IDX_BITS = $clog2(BOOK_DEPTH);
  localparam int CNT_BITS = $clog2(BOOK_DEPTH + 2);
  localparam int OW = ((3+ID_BITS+QTY_BITS+PRICE_BITS+7)/8)*8;

  state_e state_q, state_d;
  cmd_e   cmd;
  logic                  req_q;
  logic [ID_BITS-1:0]    id_q;
  logic                  side_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [QTY_BITS-1:0]   rem_q, rem_d;
  logic [31:0]           arrival_q;
  logic [31:0]           now_cnt;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [OW-1:0]         odata_q, odata_d;
  logic                  olast_q, olast_d;
  logic                  ovalid_q, ovalid_d;

  // Chain wires.
  logic                  c_hit   [BOOK_DEPTH+1];
  logic [IDX_BITS-1:0]   c_idx   [BOOK_DEPTH+1];
  logic [PRICE_BITS-1:0] c_price [BOOK_DEPTH+1];
  logic [31:0]           c_age   [BOOK_DEPTH+1];
  logic [QTY_BITS-1:0]   c_qty   [BOOK_DEPTH+1];
  logic [ID_BITS-1:0]    c_id    [BOOK_DEPTH+1];
  logic                  c_free  [BOOK_DEPTH+1];
  logic [IDX_BITS-1:0]   c_fidx  [BOOK_DEPTH+1];

  logic                  upd_en, wr_en;
  logic [QTY_BITS-1:0]   upd_qty, q_fill;
  logic                  s_acc, m_acc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;
  assign s_tready = (state_q == S_IDLE);
  assign m_tvalid = ovalid_q;
  assign m_tdata  = odata_q;
  assign m_tlast  = olast_q;

  // Chain head carries no candidate.
  assign c_hit[0]   = 1'b0;
  assign c_idx[0]   = '0;
  assign c_price[0] = '0;
  assign c_age[0]   = '0;
  assign c_qty[0]   = '0;
  assign c_id[0]    = '0;
  assign c_free[0]  = 1'b0;
  assign c_fidx[0]  = '0;

  assign cmd = (state_q == S_SCAN || state_q == S_WAIT) ?
               (req_q == REQ_CANCEL ? CMD_CANCEL : CMD_MATCH) : CMD_NONE;

  // The counter already moved on for a new order; ages use its earlier value.
  assign now_cnt = (req_q == REQ_NEW) ? arrival_q - 32'd1 : arrival_q;

  genvar g;
  generate
    for (g = 0; g < BOOK_DEPTH; g++) begin : g_cell
      lobm_cell #(
        .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS), .ID_BITS(ID_BITS),
        .IDX_BITS(IDX_BITS), .MY_IDX(IDX_BITS'(g))
      ) u_cell (
        .clk_i, .rst_ni,
        .cmd_i(cmd), .key_side_i(side_q), .key_price_i(price_q),
        .key_id_i(id_q), .now_i(now_cnt),
        .in_hit_i(c_hit[g]), .in_idx_i(c_idx[g]), .in_price_i(c_price[g]),
        .in_age_i(c_age[g]), .in_qty_i(c_qty[g]), .in_id_i(c_id[g]),
        .in_free_i(c_free[g]), .in_free_idx_i(c_fidx[g]),
        .out_hit_o(c_hit[g+1]), .out_idx_o(c_idx[g+1]),
        .out_price_o(c_price[g+1]), .out_age_o(c_age[g+1]),
        .out_qty_o(c_qty[g+1]), .out_id_o(c_id[g+1]),
        .out_free_o(c_free[g+1]), .out_free_idx_o(c_fidx[g+1]),
        .upd_en_i(upd_en), .upd_idx_i(c_idx[BOOK_DEPTH]), .upd_qty_i(upd_qty),
        .wr_en_i(wr_en), .wr_idx_i(c_fidx[BOOK_DEPTH]), .wr_side_i(side_q),
        .wr_price_i(price_q), .wr_qty_i(rem_q), .wr_id_i(id_q),
        .wr_stamp_i(now_cnt)
      );
    end
  endgenerate

  localparam logic [CNT_BITS-1:0] SWEEP = CNT_BITS'(BOOK_DEPTH);

  assign q_fill = (rem_q < c_qty[BOOK_DEPTH]) ? rem_q : c_qty[BOOK_DEPTH];

  // Controller: sweep, apply any winner, then present one result item.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    odata_d  = odata_q;
    olast_d  = olast_q;
    ovalid_d = ovalid_q && !m_acc;
    upd_en   = 1'b0;
    upd_qty  = '0;
    wr_en    = 1'b0;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (s_acc) begin
          rem_d = s_tdata[2+ID_BITS+PRICE_BITS +: QTY_BITS];
          if (s_tdata[0] == REQ_NEW && rem_d == '0) state_d = S_FINAL;
          else state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == SWEEP - CNT_BITS'(1)) state_d = S_WAIT;
      end
      S_WAIT: begin
        cnt_d = '0;
        if (!ovalid_q || m_acc) begin
          ovalid_d = 1'b1;
          if (req_q == REQ_CANCEL) begin
            olast_d = 1'b1;
            state_d = S_IDLE;
            if (c_hit[BOOK_DEPTH]) begin
              upd_en  = 1'b1;
              odata_d = OW'({c_price[BOOK_DEPTH], c_qty[BOOK_DEPTH],
                            ID_BITS'(0), ST_CANCELLED});
            end else begin
              odata_d = OW'({ID_BITS'(0), ST_NOT_FOUND});
            end
          end else if (c_hit[BOOK_DEPTH]) begin
            upd_en  = 1'b1;
            upd_qty = c_qty[BOOK_DEPTH] - q_fill;
            rem_d   = rem_q - q_fill;
            olast_d = 1'b0;
            odata_d = OW'({c_price[BOOK_DEPTH], q_fill, c_id[BOOK_DEPTH], ST_FILL});
            state_d = (rem_d == '0) ? S_FINAL : S_SCAN;
          end else begin
            ovalid_d = 1'b0;
            state_d  = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        // Remainder rests in the lowest free slot, or is rejected.
        if (!ovalid_q || m_acc) begin
          ovalid_d = 1'b1;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
          if (c_free[BOOK_DEPTH]) begin
            wr_en   = 1'b1;
            odata_d = OW'({price_q, rem_q, ID_BITS'(0), ST_RESTED});
          end else begin
            odata_d = OW'({price_q, rem_q, ID_BITS'(0), ST_BOOK_FULL});
          end
        end
      end
      S_FINAL: begin
        if (!ovalid_q || m_acc) begin
          ovalid_d = 1'b1;
          olast_d  = 1'b1;
          odata_d  = OW'(ST_FULL_FILL);
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ovalid_q  <= 1'b0;
      arrival_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
      if (s_acc && s_tdata[0] == REQ_NEW) arrival_q <= arrival_q + 32'd1;
    end
  end

  // Request and output payload.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_q   <= s_tdata[0];
      id_q    <= s_tdata[1 +: ID_BITS];
      side_q  <= s_tdata[1+ID_BITS];
      price_q <= s_tdata[2+ID_BITS +: PRICE_BITS];
    end
    rem_q   <= rem_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  // A new item is taken only when idle.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready |-> state_q == S_IDLE) else $error("ready outside idle");
  // Result presentation holds under stall.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");
  // A fill never exceeds the remaining quantity of the new order.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_en && req_q == REQ_NEW |-> q_fill <= rem_q) else $error("overfill");

endmodule : limit_order_book_matcher
`default_nettype wire

>>> rtl/core/lobm_cell.sv
// One book slot; it holds an order and passes the running best candidate on.
`default_nettype none
module lobm_cell
  import lobm_pkg::*;
#(
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 24,
  parameter int ID_BITS    = 16,
  parameter int IDX_BITS   = 5,
  parameter logic [IDX_BITS-1:0] MY_IDX = '0
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // Search key, held steady for the whole sweep.
  input  wire cmd_e             cmd_i,
  input  wire                   key_side_i,
  input  wire [PRICE_BITS-1:0]  key_price_i,
  input  wire [ID_BITS-1:0]     key_id_i,
  input  wire [31:0]            now_i,
  // Candidate from the left neighbor.
  input  wire                   in_hit_i,
  input  wire [IDX_BITS-1:0]    in_idx_i,
  input  wire [PRICE_BITS-1:0]  in_price_i,
  input  wire [31:0]            in_age_i,
  input  wire [QTY_BITS-1:0]    in_qty_i,
  input  wire [ID_BITS-1:0]     in_id_i,
  input  wire                   in_free_i,
  input  wire [IDX_BITS-1:0]    in_free_idx_i,
  // Candidate to the right neighbor.
  output logic                  out_hit_o,
  output logic [IDX_BITS-1:0]   out_idx_o,
  output logic [PRICE_BITS-1:0] out_price_o,
  output logic [31:0]           out_age_o,
  output logic [QTY_BITS-1:0]   out_qty_o,
  output logic [ID_BITS-1:0]    out_id_o,
  output logic                  out_free_o,
  output logic [IDX_BITS-1:0]   out_free_idx_o,
  // Updates addressed by slot index.
  input  wire                   upd_en_i,
  input  wire [IDX_BITS-1:0]    upd_idx_i,
  input  wire [QTY_BITS-1:0]    upd_qty_i,
  input  wire                   wr_en_i,
  input  wire [IDX_BITS-1:0]    wr_idx_i,
  input  wire                   wr_side_i,
  input  wire [PRICE_BITS-1:0]  wr_price_i,
  input  wire [QTY_BITS-1:0]    wr_qty_i,
  input  wire [ID_BITS-1:0]     wr_id_i,
  input  wire [31:0]            wr_stamp_i
);

  logic                  valid_q;
  logic                  side_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [QTY_BITS-1:0]   qty_q;
  logic [ID_BITS-1:0]    id_q;
  logic [31:0]           stamp_q;
  logic                  take;
  logic                  elig;
  logic                  crosses;
  logic                  better;
  logic [31:0]           age;

  assign age = now_i - stamp_q;

  // Decide whether this slot beats the incoming candidate.
  always_comb begin
    crosses = key_side_i ? (key_price_i <= price_q) : (key_price_i >= price_q);
    elig    = 1'b0;
    better  = 1'b0;
    case (cmd_i)
      CMD_MATCH: begin
        elig = valid_q && (side_q != key_side_i) && crosses;
        if (price_q != in_price_i) begin
          better = key_side_i ? (price_q > in_price_i) : (price_q < in_price_i);
        end else begin
          better = age > in_age_i;
        end
      end
      CMD_CANCEL: begin
        elig   = valid_q && (id_q == key_id_i);
        better = age > in_age_i;
      end
      default: begin
        elig = 1'b0;
      end
    endcase
    take = elig && (!in_hit_i || better);
  end

  // Pass the winner on, registered.
  always_ff @(posedge clk_i) begin
    out_hit_o   <= in_hit_i | take;
    out_idx_o   <= take ? MY_IDX  : in_idx_i;
    out_price_o <= take ? price_q : in_price_i;
    out_age_o   <= take ? age     : in_age_i;
    out_qty_o   <= take ? qty_q   : in_qty_i;
    out_id_o    <= take ? id_q    : in_id_i;
    out_free_o     <= in_free_i | !valid_q;
    out_free_idx_o <= in_free_i ? in_free_idx_i : MY_IDX;
  end

  // Slot valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_en_i && wr_idx_i == MY_IDX) begin
      valid_q <= 1'b1;
    end else if (upd_en_i && upd_idx_i == MY_IDX && upd_qty_i == '0) begin
      valid_q <= 1'b0;
    end
  end

  // Slot payload.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i == MY_IDX) begin
      side_q  <= wr_side_i;
      price_q <= wr_price_i;
      qty_q   <= wr_qty_i;
      id_q    <= wr_id_i;
      stamp_q <= wr_stamp_i;
    end else if (upd_en_i && upd_idx_i == MY_IDX) begin
      qty_q <= upd_qty_i;
    end
  end

endmodule : lobm_cell
`default_nettype wire
